FILE: rtl/core/ptm_pkg.sv
// shared constants, map tables and types for the pedal torque map core
package ptm_pkg;

    localparam int PEDAL_W    = 16;
    localparam int TORQUE_W   = 15;
    localparam int WHOLE_W    = 7;
    localparam int SLOPE_W    = 17;
    localparam int PROD_W     = PEDAL_W + SLOPE_W;
    localparam int FRAC_SHIFT = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 32;
    localparam int MAP_POINTS = 6;

    typedef logic [PEDAL_W-1:0]  pedal_t;
    typedef logic [TORQUE_W-1:0] torque_t;
    typedef logic [SLOPE_W-1:0]  slope_t;

    localparam pedal_t PEDAL_PTS [MAP_POINTS] = '{
        16'd9830, 16'd22938, 16'd32768, 16'd42598, 16'd49152, 16'd62259
    };
    localparam torque_t TORQUE_PTS [MAP_POINTS] = '{
        15'd0, 15'd3840, 15'd6400, 15'd7680, 15'd16640, 15'd19200
    };
    localparam slope_t SEG_SLOPE [MAP_POINTS-1] = '{
        17'd19198, 17'd17067, 17'd8533, 17'd89594, 17'd12800
    };

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FAULT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_FAULT_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_LIGHT_THR = 2'd2;

    localparam logic [CFG_W-1:0] ACCEL_FAULT_THR_RST = 16'd3277;
    localparam logic [CFG_W-1:0] BRAKE_FAULT_THR_RST = 16'd0;
    localparam logic [CFG_W-1:0] BRAKE_LIGHT_THR_RST = 16'd19661;

    typedef struct packed {
        pedal_t  offset;
        slope_t  slope;
        torque_t base;
    } seg_sel_t;

endpackage

FILE: rtl/core/ptm_seg_select.sv
// map segment lookup: base torque, slope and offset into the segment
module ptm_seg_select
    import ptm_pkg::*;
(
    input  pedal_t   accel,
    output seg_sel_t seg
);

    always_comb begin
        seg.offset = '0;
        seg.slope  = '0;
        seg.base   = TORQUE_PTS[MAP_POINTS-1];
        if (accel <= PEDAL_PTS[0]) begin
            seg.base = TORQUE_PTS[0];
        end else if (accel >= PEDAL_PTS[MAP_POINTS-1]) begin
            seg.base = TORQUE_PTS[MAP_POINTS-1];
        end else begin
            // lowest segment whose upper end covers the position wins
            for (int k = MAP_POINTS - 2; k >= 0; k--) begin
                if (accel <= PEDAL_PTS[k+1]) begin
                    seg.offset = accel - PEDAL_PTS[k];
                    seg.slope  = SEG_SLOPE[k];
                    seg.base   = TORQUE_PTS[k];
                end
            end
        end
    end

endmodule

FILE: rtl/core/pedal_torque_map_with_plausibility_core.sv
// top level of the pedal torque map core with brake plausibility check
//
// input stream s_*: one word per sample, accel and brake positions in Q0.16.
// output stream m_*: one word per sample with torque in Q7.8 Nm, whole Nm,
// brake light, plausible and the sticky inverter fault flag.
// config port cfg_*: register writes take effect at the clock edge with
// cfg_wr_en high; index 3 is ignored. write only while the core is empty.
// two register stages: the input register, then segment lookup, plausibility
// and the map multiply-add into the output register. an accepted input word
// passes the input register, then the output register; one sample is accepted
// every cycle while not stalled; lookup plus multiply-add sets the cycle time.
// each stage advances when the stage after it is empty or moving, so a
// stalled receiver fills both registers and then drops s_tready.
// reset empties the pipeline, clears the fault latch and loads the
// threshold registers with their defaults.
module pedal_torque_map_with_plausibility_core
    import ptm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] accel_position, [31:16] brake_position
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [14:0] torque_command, [21:15] torque_whole_nm, [22] brake_light,
    // [23] plausible, [24] inverter_fault, [31:25] zero
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    logic [CFG_W-1:0] accel_thr_reg;
    logic [CFG_W-1:0] brake_thr_reg;
    logic [CFG_W-1:0] light_thr_reg;

    logic     in_valid_reg;
    pedal_t   accel_reg;
    pedal_t   brake_reg;

    logic     fault_reg;
    logic     fault_next;

    logic     out_valid_reg;
    torque_t  torque_reg;
    logic     out_light_reg;
    logic     out_ok_reg;
    logic     out_fault_reg;

    logic     out_ready;
    logic     in_ready;
    seg_sel_t seg;
    logic     implausible;
    logic [PROD_W-1:0]       prod;
    logic [TORQUE_W+2:0]     sum;
    torque_t                 torque;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_thr_reg <= ACCEL_FAULT_THR_RST;
            brake_thr_reg <= BRAKE_FAULT_THR_RST;
            light_thr_reg <= BRAKE_LIGHT_THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_ACCEL_FAULT_THR: accel_thr_reg <= cfg_wr_data;
                REG_BRAKE_FAULT_THR: brake_thr_reg <= cfg_wr_data;
                REG_BRAKE_LIGHT_THR: light_thr_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            accel_reg <= s_tdata[PEDAL_W-1:0];
            brake_reg <= s_tdata[2*PEDAL_W-1:PEDAL_W];
        end
    end

    // segment lookup, plausibility and interpolation
    ptm_seg_select u_seg_select (
        .accel (accel_reg),
        .seg   (seg)
    );

    assign implausible = (accel_reg > accel_thr_reg) && (brake_reg > brake_thr_reg);
    assign fault_next  = fault_reg || implausible;

    assign prod   = PROD_W'(seg.offset) * PROD_W'(seg.slope);
    assign sum    = (TORQUE_W+3)'(seg.base) + (TORQUE_W+3)'(prod[PROD_W-1:FRAC_SHIFT]);
    assign torque = implausible ? '0 : sum[TORQUE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            fault_reg     <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                fault_reg <= fault_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            torque_reg    <= torque;
            out_light_reg <= (brake_reg >= light_thr_reg);
            out_ok_reg    <= !implausible;
            out_fault_reg <= fault_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (M_DATA_W-TORQUE_W-WHOLE_W-3)'(0),
        out_fault_reg,
        out_ok_reg,
        out_light_reg,
        torque_reg[TORQUE_W-1:TORQUE_W-WHOLE_W],
        torque_reg
    };

    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_reg |=> fault_reg)
        else $error("fault latch cleared without reset");

    a_zero_on_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ok_reg) |-> (torque_reg == '0 && out_fault_reg))
        else $error("implausible word carries torque or no fault");

    a_torque_max: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (torque_reg <= TORQUE_PTS[MAP_POINTS-1]))
        else $error("torque above map maximum");

    a_fault_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready && fault_reg) |=> out_fault_reg)
        else $error("fault flag lost between stages");

endmodule

FILE: bench/ptm_torque_checker.sv
// stream checker for the pedal torque map core: predicts each output word and compares it
`timescale 1ns / 1ps
module ptm_torque_checker
    import ptm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [15:0] accel_position, [31:16] brake_position
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [14:0] torque_command, [21:15] torque_whole_nm, [22] brake_light,
    // [23] plausible, [24] inverter_fault, [31:25] zero
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    output int                   mismatch_count,
    output int                   outstanding,
    output int                   words_checked,
    output int                   implausible_seen
);

    typedef struct packed {
        logic [6:0]         pad;
        logic               fault;
        logic               plausible;
        logic               light;
        logic [WHOLE_W-1:0] whole;
        torque_t            torque;
    } torque_word_t;

    logic [CFG_W-1:0] accel_thr;
    logic [CFG_W-1:0] brake_thr;
    logic [CFG_W-1:0] light_thr;
    logic             fault_latch;
    torque_word_t     expected_words [$];

    function automatic torque_t pedal_to_torque(pedal_t p);
        logic [PROD_W-1:0] prod;
        torque_t           t;
        t = TORQUE_PTS[0];
        if (p >= PEDAL_PTS[MAP_POINTS-1]) begin
            t = TORQUE_PTS[MAP_POINTS-1];
        end else begin
            for (int k = 0; k < MAP_POINTS - 1; k++) begin
                if (p > PEDAL_PTS[k] && p <= PEDAL_PTS[k+1]) begin
                    prod = PROD_W'(p - PEDAL_PTS[k]) * PROD_W'(SEG_SLOPE[k]);
                    t = TORQUE_PTS[k] + torque_t'(prod >> FRAC_SHIFT);
                end
            end
        end
        return t;
    endfunction

    always @(posedge aclk) begin
        torque_word_t want;
        torque_word_t got;
        pedal_t       accel;
        pedal_t       brake;
        if (!aresetn) begin
            accel_thr   = ACCEL_FAULT_THR_RST;
            brake_thr   = BRAKE_FAULT_THR_RST;
            light_thr   = BRAKE_LIGHT_THR_RST;
            fault_latch = 1'b0;
            expected_words.delete();
            outstanding = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_ACCEL_FAULT_THR: accel_thr = cfg_wr_data;
                    REG_BRAKE_FAULT_THR: brake_thr = cfg_wr_data;
                    REG_BRAKE_LIGHT_THR: light_thr = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                accel = s_tdata[PEDAL_W-1:0];
                brake = s_tdata[2*PEDAL_W-1:PEDAL_W];
                want = '0;
                want.light = (brake >= light_thr);
                if (accel > accel_thr && brake > brake_thr) begin
                    fault_latch = 1'b1;
                    implausible_seen++;
                end else begin
                    want.plausible = 1'b1;
                    want.torque    = pedal_to_torque(accel);
                    want.whole     = want.torque[TORQUE_W-1:8];
                end
                want.fault = fault_latch;
                expected_words.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                words_checked++;
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("error: output word %0d arrived with nothing expected, got %h",
                                 words_checked, m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    if (got.torque !== want.torque || got.whole !== want.whole ||
                        got.light !== want.light || got.plausible !== want.plausible ||
                        got.fault !== want.fault || got.pad !== want.pad) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"error: word %0d expected torque=%0d whole=%0d light=%b ",
                                      "ok=%b fault=%b pad=%h, got torque=%0d whole=%0d ",
                                      "light=%b ok=%b fault=%b pad=%h"},
                                     words_checked, want.torque, want.whole, want.light,
                                     want.plausible, want.fault, want.pad, got.torque,
                                     got.whole, got.light, got.plausible, got.fault, got.pad);
                    end
                end
            end
            outstanding = expected_words.size();
        end
    end

endmodule

FILE: bench/tb_pedal_torque_map_with_plausibility_core.sv
// testbench top for the pedal torque map core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_pedal_torque_map_with_plausibility_core;
    import ptm_pkg::*;

    localparam int STALL_LIMIT        = 2000;
    localparam int RANDOM_PER_SETTING = 75;
    localparam int EDGE_COUNT         = 13;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam pedal_t EDGE_ACCEL [EDGE_COUNT] = '{
        16'd0, 16'd9830, 16'd9831, 16'd22937, 16'd22938, 16'd22939, 16'd32768,
        16'd42598, 16'd42599, 16'd49152, 16'd62258, 16'd62259, 16'd65535
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    int mismatch_count;
    int outstanding;
    int words_checked;
    int implausible_seen;
    int idle_cycles   = 0;
    int rx_hold       = 0;
    int samples_sent  = 0;
    int settings_run  = 1;
    bit tx_steady;
    bit rx_steady;
    logic [CFG_W-1:0] thr_af;
    logic [CFG_W-1:0] thr_bf;
    logic [CFG_W-1:0] thr_bl;

    always #2 aclk = ~aclk;

    pedal_torque_map_with_plausibility_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    ptm_torque_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .mismatch_count   (mismatch_count),
        .outstanding      (outstanding),
        .words_checked    (words_checked),
        .implausible_seen (implausible_seen)
    );

    // receiver back-pressure: mostly short stalls, a few long ones
    always @(negedge aclk) begin
        int pick;
        if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m_tready <= 1'b1;
                rx_hold  <= $urandom_range(0, 12);
            end else if (pick < 94) begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(15, 60);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_sample(input pedal_t accel, input pedal_t brake);
        int gap;
        int r;
        gap = 0;
        if (!tx_steady) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gap = 0;
            else if (r < 88)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {brake, accel};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
        @(negedge aclk);
    endtask

    function automatic pedal_t pick_pedal(input logic [CFG_W-1:0] thr);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 25)
            v = $urandom_range(0, 65535);
        else if (r < 45)
            v = int'(PEDAL_PTS[$urandom_range(0, MAP_POINTS-1)]) + $urandom_range(0, 4) - 2;
        else if (r < 55)
            v = $urandom_range(0, 1) ? 65535 : 0;
        else if (r < 75)
            v = int'(thr) + $urandom_range(0, 4) - 2;
        else
            v = $urandom_range(0, int'(thr));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return pedal_t'(v);
    endfunction

    task automatic run_random(input int count);
        pedal_t accel;
        pedal_t brake;
        repeat (count) begin
            accel = pick_pedal(thr_af);
            brake = pick_pedal($urandom_range(0, 1) ? thr_bf : thr_bl);
            send_sample(accel, brake);
        end
    endtask

    // waits for the pipeline to drain, then writes all three thresholds and the spare index
    task automatic program_thresholds(input logic [CFG_W-1:0] af, input logic [CFG_W-1:0] bf,
                                      input logic [CFG_W-1:0] bl);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_ACCEL_FAULT_THR;
        cfg_wr_data  <= af;
        @(negedge aclk);
        cfg_wr_index <= REG_BRAKE_FAULT_THR;
        cfg_wr_data  <= bf;
        @(negedge aclk);
        cfg_wr_index <= REG_BRAKE_LIGHT_THR;
        cfg_wr_data  <= bl;
        @(negedge aclk);
        cfg_wr_index <= REG_UNUSED;
        cfg_wr_data  <= $urandom;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        thr_af = af;
        thr_bf = bf;
        thr_bl = bl;
        settings_run++;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_ACCEL_FAULT_THR;
        cfg_wr_data  = '0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        thr_af       = ACCEL_FAULT_THR_RST;
        thr_bf       = BRAKE_FAULT_THR_RST;
        thr_bl       = BRAKE_LIGHT_THR_RST;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // map breakpoints and clamps with the brake released
        for (int i = 0; i < EDGE_COUNT; i++)
            send_sample(EDGE_ACCEL[i], 16'd0);
        // brake light edge, accel at its fault threshold, then the first fault
        send_sample(ACCEL_FAULT_THR_RST, BRAKE_LIGHT_THR_RST - 16'd1);
        send_sample(ACCEL_FAULT_THR_RST, BRAKE_LIGHT_THR_RST);
        send_sample(ACCEL_FAULT_THR_RST, 16'hFFFF);
        send_sample(ACCEL_FAULT_THR_RST + 16'd1, 16'd1);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'd32768, 16'd0);
        run_random(RANDOM_PER_SETTING);

        program_thresholds(16'd0, 16'd0, 16'd0);
        run_random(RANDOM_PER_SETTING);

        tx_steady = 1'b1;
        rx_steady = 1'b1;
        program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(RANDOM_PER_SETTING);
        rx_steady = 1'b0;

        repeat (3) begin
            program_thresholds(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
            run_random(RANDOM_PER_SETTING);
            tx_steady = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("run covered %0d pedal samples and %0d checked words over %0d threshold settings",
                 samples_sent, words_checked, settings_run);
        $display("%0d of those samples failed the pedal plausibility check", implausible_seen);
        if (mismatch_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
